@@ rtl/core/wit_pkg.sv @@
// Package for the windowed interval timer.
// Holds field widths, action, event, mode and register codes, and the result record.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps
`default_nettype none

package wit_pkg;

  localparam int unsigned TimeW = 53;
  localparam int unsigned SpanW = 52;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [SpanW-1:0] WindowGapUs = SpanW'(100000);

  typedef enum logic [2:0] {
    ACT_START     = 3'd0,
    ACT_TICK      = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_PAUSE     = 3'd3,
    ACT_RESUME    = 3'd4,
    ACT_RESET_IVL = 3'd5
  } action_e;

  typedef enum logic [2:0] {
    EV_WAIT    = 3'd0,
    EV_START   = 3'd1,
    EV_ERROR   = 3'd2,
    EV_END     = 3'd3,
    EV_TRIG    = 3'd4,
    EV_MAXWORK = 3'd5,
    EV_REJECT  = 3'd6
  } event_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_WAIT = 2'd1,
    MODE_RUN  = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_START_TIME = 2'd0,
    REG_END_TIME   = 2'd1,
    REG_INTERVAL   = 2'd2,
    REG_MAX_WORK   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    event_e           ev;
    logic [TimeW-1:0] tstamp;
    logic             last;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/core/wit_intf.sv @@
// Valid/ready channel interfaces of the windowed interval timer.
// Input request, result and register write channels; depends on wit_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface wit_in_if import wit_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       action;
  logic [TimeW-1:0] now_us;

  modport source (output valid, action, now_us, input ready);
  modport sink (input valid, action, now_us, output ready);
endinterface

interface wit_out_if import wit_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [2:0]       event_res;
  logic [TimeW-1:0] event_time_us;
  logic             last_of_run;

  modport source (output valid, event_res, event_time_us, last_of_run, input ready);
  modport sink (input valid, event_res, event_time_us, last_of_run, output ready);
endinterface

interface wit_cfg_if import wit_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [TimeW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ rtl/core/windowed_interval_timer.sv @@
// Windowed interval timer: input register, one pass of compare logic, result buffer.
// A request's results are registered; one request per cycle while the result buffer has room.
// A request with two results holds the result buffer for two output transfers.
// The pass reads and updates the timer state and only reads the configuration registers.
// Reset is asynchronous and clears the mode, flags, buffer counts and configuration registers.
// Depends on wit_pkg and the channel interfaces in wit_intf.sv.
`timescale 1ns / 1ps
`default_nettype none

module windowed_interval_timer import wit_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  wit_cfg_if.sink   cfg_i,
  wit_in_if.sink    in_i,
  wit_out_if.source out_o
);

  logic [TimeW-1:0] start_time_q, end_time_q;
  logic [SpanW-1:0] interval_q, max_work_q;

  logic             in_valid_q;
  logic [2:0]       in_action_q;
  logic [TimeW-1:0] in_now_q;

  mode_e            mode_q, mode_d;
  logic             phase_q, phase_d;
  logic             pause_q, pause_d;
  logic             rpend_q, rpend_d;
  logic [TimeW-1:0] ltt_q, ltt_d;

  res_t             res0_q, res1_q, res0_d, res1_d;
  logic [1:0]       cnt_q, cnt_d;

  logic             fire, pop, settings_ok, trig, phase_mid;
  logic [TimeW-1:0] elapsed, elapsed_eff, work;
  logic [SpanW-1:0] ivl_less_gap;
  logic [1:0]       nres;
  event_e           ev0, ev1;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_time_q <= '0;
      end_time_q   <= '0;
      interval_q   <= '0;
      max_work_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        REG_START_TIME: start_time_q <= cfg_i.data;
        REG_END_TIME:   end_time_q   <= cfg_i.data;
        REG_INTERVAL:   interval_q   <= cfg_i.data[SpanW-1:0];
        REG_MAX_WORK:   max_work_q   <= cfg_i.data[SpanW-1:0];
        default: ;
      endcase
    end
  end

  assign pop         = out_o.valid && out_o.ready;
  assign fire        = in_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready));
  assign in_i.ready  = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_action_q <= in_i.action;
      in_now_q    <= in_i.now_us;
    end
  end

  assign ivl_less_gap = interval_q - WindowGapUs;
  assign settings_ok  = (interval_q != '0) && (end_time_q >= start_time_q) &&
                        ((max_work_q == '0) ||
                         ((interval_q > WindowGapUs) && (max_work_q < ivl_less_gap)));

  assign elapsed     = in_now_q - ltt_q;
  assign elapsed_eff = rpend_q ? '0 : elapsed;
  assign trig        = !phase_q && (elapsed_eff >= {1'b0, interval_q});
  assign phase_mid   = phase_q || trig;
  assign work        = trig ? '0 : elapsed_eff;

  always_comb begin
    mode_d  = mode_q;
    phase_d = phase_q;
    pause_d = pause_q;
    rpend_d = rpend_q;
    ltt_d   = ltt_q;
    nres    = 2'd0;
    ev0     = EV_WAIT;
    ev1     = EV_WAIT;
    unique case (in_action_q)
      ACT_START: begin
        nres = 2'd1;
        if (settings_ok) begin
          pause_d = 1'b0;
          mode_d  = MODE_WAIT;
          ev0     = EV_WAIT;
        end else begin
          ev0 = EV_REJECT;
        end
      end
      ACT_TICK: begin
        if (mode_q == MODE_WAIT) begin
          if (in_now_q >= start_time_q) begin
            mode_d  = MODE_RUN;
            phase_d = 1'b0;
            ltt_d   = '0;
            nres    = 2'd1;
            ev0     = EV_START;
          end else if (in_now_q > end_time_q) begin
            mode_d = MODE_IDLE;
            nres   = 2'd1;
            ev0    = EV_ERROR;
          end
        end else if ((mode_q == MODE_RUN) && !pause_q) begin
          if (in_now_q >= end_time_q) begin
            mode_d = MODE_IDLE;
            nres   = 2'd1;
            ev0    = EV_END;
          end else begin
            rpend_d = 1'b0;
            if (rpend_q || trig) begin
              ltt_d = in_now_q;
            end
            phase_d = phase_mid;
            if (trig) begin
              nres = 2'd1;
              ev0  = EV_TRIG;
            end
            if (phase_mid && ((max_work_q == '0) || (work >= {1'b0, max_work_q}))) begin
              phase_d = 1'b0;
              if (trig) begin
                nres = 2'd2;
                ev1  = EV_MAXWORK;
              end else begin
                nres = 2'd1;
                ev0  = EV_MAXWORK;
              end
            end
          end
        end
      end
      ACT_STOP: begin
        if (mode_q == MODE_WAIT) begin
          nres = 2'd1;
          ev0  = EV_ERROR;
        end
        mode_d = MODE_IDLE;
      end
      ACT_PAUSE:     pause_d = 1'b1;
      ACT_RESUME:    pause_d = 1'b0;
      ACT_RESET_IVL: rpend_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      phase_q <= 1'b0;
      pause_q <= 1'b0;
      rpend_q <= 1'b0;
      ltt_q   <= '0;
    end else if (fire) begin
      mode_q  <= mode_d;
      phase_q <= phase_d;
      pause_q <= pause_d;
      rpend_q <= rpend_d;
      ltt_q   <= ltt_d;
    end
  end

  always_comb begin
    res0_d = res0_q;
    res1_d = res1_q;
    cnt_d  = cnt_q;
    if (fire) begin
      res0_d = '{ev: ev0, tstamp: in_now_q, last: (nres == 2'd1)};
      res1_d = '{ev: ev1, tstamp: in_now_q, last: 1'b1};
      cnt_d  = nres;
    end else if (pop) begin
      res0_d = res1_q;
      cnt_d  = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res0_q <= res0_d;
    res1_q <= res1_d;
  end

  assign out_o.valid         = (cnt_q != 2'd0);
  assign out_o.event_res     = res0_q.ev;
  assign out_o.event_time_us = res0_q.tstamp;
  assign out_o.last_of_run   = res0_q.last;

  a_first_of_two_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd2) |-> !res0_q.last)
    else $error("first of two buffered results is marked last");

  a_single_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd1) |-> res0_q.last)
    else $error("sole buffered result is not marked last");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_valid_q)
    else $error("input stalled with no request held");

  a_run_from_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((mode_q == MODE_RUN) && ($past(mode_q) != MODE_RUN)) |-> ($past(mode_q) == MODE_WAIT))
    else $error("running entered from a mode other than waiting");

  a_buffer_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (cnt_q == $past(nres)))
    else $error("result count does not match the pass that loaded it");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Self-checking testbench for the windowed interval timer.
// Drives timer requests and register writes, predicts every event and checks it.
// Depends on wit_pkg, the channel interfaces and the windowed_interval_timer top level.
`timescale 1ns / 1ps

import wit_pkg::*;

class event_scoreboard;
  logic [TimeW-1:0] start_t, end_t, last_trig;
  logic [SpanW-1:0] ivl, max_work;
  mode_e            mode;
  logic             work_open, paused, reset_armed;
  res_t             expected_events[$];
  res_t             batch[$];
  int               errors;

  function new();
    start_t     = '0;
    end_t       = '0;
    ivl         = '0;
    max_work    = '0;
    mode        = MODE_IDLE;
    work_open   = 1'b0;
    paused      = 1'b0;
    reset_armed = 1'b0;
    last_trig   = '0;
    errors      = 0;
  endfunction

  function void apply_write(cfg_idx_e idx, logic [TimeW-1:0] data);
    case (idx)
      REG_START_TIME: start_t = data;
      REG_END_TIME:   end_t = data;
      REG_INTERVAL:   ivl = data[SpanW-1:0];
      REG_MAX_WORK:   max_work = data[SpanW-1:0];
      default: ;
    endcase
  endfunction

  function bit settings_ok();
    if (ivl == 0) return 1'b0;
    if (end_t < start_t) return 1'b0;
    if (max_work != 0) begin
      if (ivl <= WindowGapUs) return 1'b0;
      if (max_work >= ivl - WindowGapUs) return 1'b0;
    end
    return 1'b1;
  endfunction

  function void emit(event_e ev, logic [TimeW-1:0] t);
    res_t r;
    r.ev     = ev;
    r.tstamp = t;
    r.last   = 1'b0;
    batch.push_back(r);
  endfunction

  function void predict_events(logic [2:0] act, logic [TimeW-1:0] now);
    logic [TimeW-1:0] elapsed;
    batch.delete();
    case (act)
      ACT_START: begin
        if (settings_ok()) begin
          paused = 1'b0;
          mode   = MODE_WAIT;
          emit(EV_WAIT, now);
        end else begin
          emit(EV_REJECT, now);
        end
      end
      ACT_TICK: begin
        if (mode == MODE_WAIT) begin
          if (now >= start_t) begin
            mode      = MODE_RUN;
            work_open = 1'b0;
            last_trig = '0;
            emit(EV_START, now);
          end else if (now > end_t) begin
            mode = MODE_IDLE;
            emit(EV_ERROR, now);
          end
        end else if (mode == MODE_RUN && !paused) begin
          if (now >= end_t) begin
            mode = MODE_IDLE;
            emit(EV_END, now);
          end else begin
            elapsed = now - last_trig;
            if (reset_armed) begin
              reset_armed = 1'b0;
              last_trig   = now;
              elapsed     = '0;
            end
            if (!work_open && elapsed >= ivl) begin
              work_open = 1'b1;
              last_trig = now;
              emit(EV_TRIG, now);
            end
            if (work_open && (max_work == 0 || TimeW'(now - last_trig) >= max_work)) begin
              work_open = 1'b0;
              emit(EV_MAXWORK, now);
            end
          end
        end
      end
      ACT_STOP: begin
        if (mode == MODE_WAIT) emit(EV_ERROR, now);
        mode = MODE_IDLE;
      end
      ACT_PAUSE:     paused = 1'b1;
      ACT_RESUME:    paused = 1'b0;
      ACT_RESET_IVL: reset_armed = 1'b1;
      default: ;
    endcase
    if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
    foreach (batch[k]) expected_events.push_back(batch[k]);
  endfunction

  function void check_event(logic [2:0] ev, logic [TimeW-1:0] t, logic last);
    res_t exp_ev;
    if (expected_events.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected event: ev=%0d t=%0d last=%0d", ev, t, last);
      return;
    end
    exp_ev = expected_events.pop_front();
    if (ev !== exp_ev.ev || t !== exp_ev.tstamp || last !== exp_ev.last) begin
      errors++;
      if (errors <= 10) begin
        $display("mismatch: expected ev=%0d t=%0d last=%0d, got ev=%0d t=%0d last=%0d",
                 exp_ev.ev, exp_ev.tstamp, exp_ev.last, ev, t, last);
      end
    end
  endfunction
endclass

module tb import wit_pkg::*; ();

  localparam int               RandomItems = 1950;
  localparam logic [TimeW-1:0] TimeMax = '1;

  logic clk_i;
  logic rst_ni;

  wit_cfg_if cfg_if ();
  wit_in_if  in_if ();
  wit_out_if out_if ();

  windowed_interval_timer uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  event_scoreboard  sb;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int               n_random;
  logic [TimeW-1:0] cur;
  logic [63:0]      pace;

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    in_if.valid   = 1'b0;
    in_if.action  = '0;
    in_if.now_us  = '0;
    out_if.ready  = 1'b0;
    src_idle_pct  = 31;
    sink_idle_pct = 72;
  end

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= sink_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_event(out_if.event_res, out_if.event_time_us, out_if.last_of_run);
    end
  end

  function automatic logic [63:0] rand_below(logic [63:0] lim);
    return {$urandom, $urandom} % lim;
  endfunction

  function automatic logic [TimeW-1:0] rand_time();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[TimeW-1:0];
  endfunction

  function automatic logic [TimeW-1:0] advance(logic [TimeW-1:0] t, logic [63:0] step);
    if (step > 64'(TimeMax - t)) return TimeMax;
    return t + TimeW'(step);
  endfunction

  task automatic send_req(logic [2:0] act, logic [TimeW-1:0] now);
    @(negedge clk_i);
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  = 1'b1;
    in_if.action = act;
    in_if.now_us = now;
    do @(posedge clk_i); while (!in_if.ready);
    sb.predict_events(act, now);
  endtask

  task automatic settle();
    int waited = 0;
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (sb.expected_events.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [TimeW-1:0] val);
    @(negedge clk_i);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = val;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.apply_write(idx, val);
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic configure(logic [TimeW-1:0] s, logic [TimeW-1:0] e,
                           logic [TimeW-1:0] i, logic [TimeW-1:0] m);
    cfg_write(REG_START_TIME, s);
    cfg_write(REG_END_TIME, e);
    cfg_write(REG_INTERVAL, i);
    cfg_write(REG_MAX_WORK, m);
  endtask

  task automatic directed_requests();
    send_req(ACT_TICK, 53'd0);
    send_req(ACT_STOP, TimeMax);
    send_req(ACT_START, 53'd0);
    settle();
    configure(53'd1000000, 53'd10000000, 53'd500000, 53'd200000);
    send_req(ACT_START, 53'd0);
    send_req(ACT_TICK, 53'd500);
    send_req(ACT_TICK, 53'd1000000);
    send_req(ACT_TICK, 53'd1000001);
    send_req(ACT_TICK, 53'd1200001);
    send_req(ACT_PAUSE, 53'd0);
    send_req(ACT_TICK, 53'd1800000);
    send_req(ACT_RESUME, 53'd0);
    send_req(ACT_RESET_IVL, 53'd0);
    send_req(ACT_TICK, 53'd1900000);
    send_req(ACT_TICK, 53'd2400000);
    send_req(ACT_TICK, 53'd10000000);
    send_req(3'd6, TimeMax);
    send_req(3'd7, 53'd0);
    send_req(ACT_START, 53'd5);
    send_req(ACT_STOP, 53'd6);
    send_req(ACT_START, 53'd7);
    settle();
    cfg_write(REG_END_TIME, 53'd100);
    send_req(ACT_TICK, 53'd200);
    settle();
    configure(TimeMax, TimeMax, 53'd4294967295000000, 53'd0);
    send_req(ACT_START, TimeMax);
    send_req(ACT_TICK, TimeMax);
    send_req(ACT_TICK, TimeMax);
    settle();
    configure(53'd0, TimeMax, 53'd1, 53'd0);
    send_req(ACT_START, 53'd0);
    send_req(ACT_TICK, 53'd0);
    send_req(ACT_TICK, 53'd5);
    send_req(ACT_STOP, 53'd9);
    settle();
    configure(53'd0, 53'd10, 53'd100000, 53'd1);
    send_req(ACT_START, 53'd0);
    settle();
    cfg_write(REG_INTERVAL, 53'd300000);
    cfg_write(REG_MAX_WORK, 53'd200000);
    send_req(ACT_START, 53'd0);
    settle();
    cfg_write(REG_MAX_WORK, 53'd199999);
    send_req(ACT_START, 53'd0);
    settle();
  endtask

  task automatic random_settings();
    logic [63:0]      s, e, i, m, span;
    int unsigned      p;
    p = $urandom_range(99);
    if (p < 4) i = 0;
    else if (p < 10) i = 64'($urandom_range(1, 100000));
    else if (p < 14) i = 64'd4294967295000000;
    else i = 64'($urandom_range(100001, 3000000));
    p = $urandom_range(99);
    if (p < 25) m = 0;
    else if (p < 33 && i > 100000) m = i - 100000 + rand_below(10);
    else if (i > 100001) m = 1 + rand_below(i - 100001);
    else m = 64'($urandom_range(1, 1000));
    p = $urandom_range(99);
    if (p < 8) s = 64'(TimeMax) - rand_below(20000000);
    else if (p < 14) s = 0;
    else s = 64'(rand_time());
    pace = (i == 0) ? 64'd500000 : i;
    p = $urandom_range(99);
    if (p < 5 && s > 0) begin
      e = s - 1;
    end else if (p < 9) begin
      e = s;
    end else begin
      span = rand_below(pace * 30 + 1);
      e = (span > 64'(TimeMax) - s) ? 64'(TimeMax) : s + span;
    end
    configure(s[TimeW-1:0], e[TimeW-1:0], i[TimeW-1:0], m[TimeW-1:0]);
    span = rand_below(2 * pace + 1);
    cur = (s > span) ? TimeW'(s - span) : '0;
  endtask

  task automatic run_scenario();
    int          len;
    int unsigned p;
    logic [63:0] step;
    logic [63:0] back;
    random_settings();
    send_req(ACT_START, cur);
    n_random++;
    len = $urandom_range(20, 50);
    repeat (len) begin
      p = $urandom_range(99);
      if (p < 6) begin
        send_req(ACT_START, cur);
      end else if (p < 68) begin
        p = $urandom_range(99);
        if (p < 10) step = 0;
        else if (p < 70) step = rand_below(pace / 2 + 1);
        else if (p < 95) step = rand_below(pace * 2 + 1);
        else step = rand_below(pace * 20 + 1);
        cur = advance(cur, step);
        send_req(ACT_TICK, cur);
      end else if (p < 72) begin
        send_req(ACT_STOP, cur);
      end else if (p < 77) begin
        send_req(ACT_PAUSE, cur);
      end else if (p < 84) begin
        send_req(ACT_RESUME, cur);
      end else if (p < 89) begin
        send_req(ACT_RESET_IVL, cur);
      end else if (p < 92) begin
        settle();
        back = rand_below(1000) + 1;
        cfg_write(REG_END_TIME, (64'(cur) > back) ? TimeW'(64'(cur) - back) : '0);
        continue;
      end else begin
        send_req(3'($urandom_range(7)), rand_time());
      end
      n_random++;
    end
    settle();
  endtask

  initial begin
    sb = new();
    n_random = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    directed_requests();
    while (n_random < RandomItems) begin
      case (n_random * 3 / RandomItems)
        0: begin
          src_idle_pct  = 31;
          sink_idle_pct = 72;
        end
        1: begin
          src_idle_pct  = 72;
          sink_idle_pct = 31;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      run_scenario();
    end
    settle();
    if (sb.errors == 0 && sb.expected_events.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

@@ sim.f @@
rtl/core/wit_pkg.sv
rtl/core/wit_intf.sv
rtl/core/windowed_interval_timer.sv
sim/tb.sv
